// ===== rtl/tccw_pkg.sv =====
// shared types and constants for the text console character writer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int TAB_STOP   = 8;

  // port field widths
  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int ATTR_W    = 8;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DELETE    = 8'h7F;

  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_BACKSPACE,
    CMD_TAB,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  ch;
    logic [ADDR_W-1:0]  idx;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tccw_front.sv =====
// front end: accepts input items, classifies them into commands
// depends on tccw_pkg; feeds tccw_queue
`timescale 1ns / 1ps
`default_nettype none

module tccw_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [tccw_pkg::OPCODE_W-1:0] in_opcode,
  input  wire [tccw_pkg::CHAR_W-1:0]   in_char_code,
  input  wire [tccw_pkg::INDEX_W-1:0]  in_cell_index,
  input  wire                          hold,
  output logic                         push,
  output tccw_pkg::cmd_t               push_cmd,
  input  wire                          q_ready
);
  import tccw_pkg::*;

  logic  f_valid_r;
  cmd_t  f_cmd_r;
  cmd_t  cmd_nxt;
  logic  accept;

  always_comb begin
    cmd_nxt.ch   = in_char_code;
    cmd_nxt.idx  = ADDR_W'(in_cell_index);
    cmd_nxt.kind = CMD_NOP;
    unique case (in_opcode)
      OP_PUT: begin
        unique case (in_char_code)
          CH_NEWLINE:             cmd_nxt.kind = CMD_NEWLINE;
          CH_RETURN:              cmd_nxt.kind = CMD_RETURN;
          CH_BACKSPACE, CH_DELETE: cmd_nxt.kind = CMD_BACKSPACE;
          CH_TAB:                 cmd_nxt.kind = CMD_TAB;
          default:                cmd_nxt.kind = CMD_PRINT;
        endcase
      end
      OP_READ: begin
        // out of range reads leave the screen alone and return zeros
        if (int'(in_cell_index) < CELL_COUNT) begin
          cmd_nxt.kind = CMD_READ;
        end else begin
          cmd_nxt.kind = CMD_NOP;
        end
      end
      OP_CLEAR: cmd_nxt.kind = CMD_CLEAR;
      default:  cmd_nxt.kind = CMD_NOP;
    endcase
  end

  assign in_stall = hold || (f_valid_r && !q_ready);
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid_r && q_ready;
  assign push_cmd = f_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccw_queue.sv =====
// short command queue between the front and back ends
// depends on tccw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tccw_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire tccw_pkg::cmd_t push_cmd,
  output logic                q_ready,
  output logic                q_valid,
  output tccw_pkg::cmd_t      q_cmd,
  input  wire                 pop
);
  import tccw_pkg::*;

  cmd_t              entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign q_ready = cnt_r != QCNT_W'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_cmd   = entries_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccw_back.sv =====
// back end: cursor, screen memory, fill sweeps and the result register
// depends on tccw_pkg; takes commands from tccw_queue
`timescale 1ns / 1ps
`default_nettype none

module tccw_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [tccw_pkg::ATTR_W-1:0]    cfg_wdata,
  input  wire                           q_valid,
  input  wire tccw_pkg::cmd_t           q_cmd,
  output logic                          pop,
  output logic                          init_busy,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [tccw_pkg::OUT_COL_W-1:0] out_cursor_col,
  output logic [tccw_pkg::OUT_ROW_W-1:0] out_cursor_row,
  output logic [tccw_pkg::CHAR_W-1:0]   out_cell_char,
  output logic [tccw_pkg::ATTR_W-1:0]   out_cell_attr
);
  import tccw_pkg::*;

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_READ, ST_FILL} state_t;

  state_t                       state_r;
  logic [COL_W-1:0]             col_r;
  logic [ROW_W-1:0]             row_r;
  logic [ADDR_W-1:0]            base_r;
  logic [ADDR_W-1:0]            fill_addr_r;
  logic [ADDR_W-1:0]            fill_end_r;
  logic [ATTR_W-1:0]            fill_attr_r;
  logic [ATTR_W-1:0]            attr_r;
  logic                         out_valid_r;
  logic [OUT_COL_W-1:0]         out_col_r;
  logic [OUT_ROW_W-1:0]         out_row_r;
  logic [CHAR_W-1:0]            out_char_r;
  logic [ATTR_W-1:0]            out_attr_r;

  logic [ATTR_W+CHAR_W-1:0]     mem [CELL_COUNT];
  logic [ATTR_W+CHAR_W-1:0]     rd_data_r;

  logic                         out_free;
  logic                         res_load;
  logic [COL_W-1:0]             col_nxt;
  logic [ROW_W-1:0]             row_nxt;
  logic                         adv;
  logic                         scroll;
  logic                         cur_we;
  logic [COL_W-1:0]             wr_col;
  logic [CHAR_W-1:0]            wr_char;
  logic [COL_W:0]               tab_sum;
  logic [ADDR_W:0]              cur_sum;
  logic [ADDR_W-1:0]            cur_addr;
  logic [ADDR_W-1:0]            rd_addr;
  logic [ADDR_W:0]              base_sum;
  logic [ADDR_W-1:0]            base_nxt;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_addr;
  logic [ATTR_W+CHAR_W-1:0]     mem_wdata;

  // logical to physical cell address; the top row rotates on scroll
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W:0] sum);
    logic [ADDR_W:0] red;
    red = sum - (ADDR_W+1)'(CELL_COUNT);
    return (sum >= (ADDR_W+1)'(CELL_COUNT)) ? red[ADDR_W-1:0] : sum[ADDR_W-1:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_IDLE) && q_valid && out_free;
  assign init_busy = state_r == ST_INIT;

  assign tab_sum = ({1'b0, col_r} + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);

  always_comb begin
    col_nxt = col_r;
    adv     = 1'b0;
    cur_we  = 1'b0;
    wr_col  = col_r;
    wr_char = q_cmd.ch;
    unique case (q_cmd.kind)
      CMD_PRINT: begin
        cur_we = 1'b1;
        if (col_r == COL_W'(COLUMNS - 1)) begin
          col_nxt = '0;
          adv     = 1'b1;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      CMD_NEWLINE: begin
        col_nxt = '0;
        adv     = 1'b1;
      end
      CMD_RETURN: col_nxt = '0;
      CMD_BACKSPACE: begin
        if (col_r != '0) begin
          col_nxt = col_r - COL_W'(1);
          wr_col  = col_r - COL_W'(1);
          wr_char = BLANK_CHAR;
          cur_we  = 1'b1;
        end
      end
      CMD_TAB: begin
        if (tab_sum >= (COL_W+1)'(COLUMNS)) begin
          col_nxt = '0;
          adv     = 1'b1;
        end else begin
          col_nxt = tab_sum[COL_W-1:0];
        end
      end
      CMD_READ, CMD_CLEAR, CMD_NOP: col_nxt = col_r;
      default: col_nxt = col_r;
    endcase
  end

  assign scroll  = adv && (row_r == ROW_W'(ROWS - 1));
  assign row_nxt = (adv && !scroll) ? row_r + ROW_W'(1) : row_r;

  // a new result is loaded at this edge
  assign res_load = (state_r == ST_READ)
                    || (state_r == ST_FILL && fill_addr_r == fill_end_r)
                    || (pop && q_cmd.kind != CMD_READ && q_cmd.kind != CMD_CLEAR && !scroll);

  assign cur_sum  = (ADDR_W+1)'(row_r) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(wr_col)
                    + (ADDR_W+1)'(base_r);
  assign cur_addr = wrap_addr(cur_sum);
  assign rd_addr  = wrap_addr((ADDR_W+1)'(q_cmd.idx) + (ADDR_W+1)'(base_r));

  assign base_sum = {1'b0, base_r} + (ADDR_W+1)'(COLUMNS);
  assign base_nxt = (base_sum == (ADDR_W+1)'(CELL_COUNT)) ? '0 : base_sum[ADDR_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur_addr;
    mem_wdata = {attr_r, wr_char};
    if (state_r == ST_INIT || state_r == ST_FILL) begin
      mem_we    = 1'b1;
      mem_addr  = fill_addr_r;
      mem_wdata = {fill_attr_r, BLANK_CHAR};
    end else if (pop && cur_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      fill_addr_r <= '0;
      fill_end_r  <= ADDR_W'(CELL_COUNT - 1);
      fill_attr_r <= RESET_ATTR;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && !res_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT, ST_FILL: begin
          fill_addr_r <= fill_addr_r + ADDR_W'(1);
          if (fill_addr_r == fill_end_r) begin
            state_r <= ST_IDLE;
            // the power-up sweep gives no result
            if (state_r == ST_FILL) begin
              out_valid_r <= 1'b1;
              out_col_r   <= OUT_COL_W'(col_r);
              out_row_r   <= OUT_ROW_W'(row_r);
              out_char_r  <= '0;
              out_attr_r  <= '0;
            end
          end
        end
        ST_IDLE: begin
          if (pop) begin
            priority case (q_cmd.kind)
              CMD_READ: state_r <= ST_READ;
              CMD_CLEAR: begin
                col_r       <= '0;
                row_r       <= '0;
                base_r      <= '0;
                fill_addr_r <= '0;
                fill_end_r  <= ADDR_W'(CELL_COUNT - 1);
                fill_attr_r <= attr_r;
                state_r     <= ST_FILL;
              end
              default: begin
                col_r <= col_nxt;
                row_r <= row_nxt;
                if (scroll) begin
                  // old top row becomes the new, blank bottom row
                  base_r      <= base_nxt;
                  fill_addr_r <= base_r;
                  fill_end_r  <= base_r + ADDR_W'(COLUMNS - 1);
                  fill_attr_r <= attr_r;
                  state_r     <= ST_FILL;
                end else begin
                  out_valid_r <= 1'b1;
                  out_col_r   <= OUT_COL_W'(col_nxt);
                  out_row_r   <= OUT_ROW_W'(row_nxt);
                  out_char_r  <= '0;
                  out_attr_r  <= '0;
                end
              end
            endcase
          end
        end
        ST_READ: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          out_col_r   <= OUT_COL_W'(col_r);
          out_row_r   <= OUT_ROW_W'(row_r);
          out_char_r  <= rd_data_r[CHAR_W-1:0];
          out_attr_r  <= rd_data_r[ATTR_W+CHAR_W-1:CHAR_W];
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

endmodule

`default_nettype wire

// ===== rtl/text_console_char_writer_unit.sv =====
// text console character writer, top level
// depends on tccw_pkg, tccw_front, tccw_queue, tccw_back
//
// usage: one input item per put-character, read-cell or clear-screen
// request (in_opcode, in_char_code, in_cell_index) and one result item per
// input (cursor after the operation, and the cell bytes for a read).
// cfg_we/cfg_wdata set the attribute byte used for newly written cells.
// path: an item is registered in the front register and then in the queue;
// the back end then handles put character, return, newline, tab and
// backspace directly, reads a cell through the registered screen memory
// port, and blanks one row when the cursor leaves the last row and the
// whole screen for clear screen, through the single memory write port.
// sustained rate is one item per cycle for plain characters while out_stall
// is low; a read keeps the back end busy until its result is loaded.
// after reset the block blanks the whole screen to spaces with attribute 7,
// one cell a cycle, and holds in_stall high meanwhile.
// when out_stall is high the result register holds; the front and queue
// keep taking items until both are full, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [tccw_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire  [tccw_pkg::CHAR_W-1:0]     in_char_code,
  input  wire  [tccw_pkg::INDEX_W-1:0]    in_cell_index,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [tccw_pkg::OUT_COL_W-1:0]  out_cursor_col,
  output logic [tccw_pkg::OUT_ROW_W-1:0]  out_cursor_row,
  output logic [tccw_pkg::CHAR_W-1:0]     out_cell_char,
  output logic [tccw_pkg::ATTR_W-1:0]     out_cell_attr,
  input  wire                             cfg_we,
  input  wire  [tccw_pkg::ATTR_W-1:0]     cfg_wdata
);
  import tccw_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;
  logic init_busy;

  tccw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .hold          (init_busy),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_ready       (q_ready)
  );

  tccw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  tccw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .pop            (pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr)
  );

endmodule

`default_nettype wire

// ===== rtl/tccw_checker.sv =====
// port-level checks for the text console character writer
// depends on tccw_pkg; bound to text_console_char_writer_unit
`timescale 1ns / 1ps
`default_nettype none

module tccw_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_stall,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire [tccw_pkg::OUT_COL_W-1:0]   out_cursor_col,
  input wire [tccw_pkg::OUT_ROW_W-1:0]   out_cursor_row,
  input wire [tccw_pkg::CHAR_W-1:0]      out_cell_char,
  input wire [tccw_pkg::ATTR_W-1:0]      out_cell_attr
);
  import tccw_pkg::*;

  // the screen blanking pass after reset takes no items
  a_init_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during power-up blanking");

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_col)
      && $stable(out_cursor_row) && $stable(out_cell_char) && $stable(out_cell_attr))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_col) < COLUMNS) && (int'(out_cursor_row) < ROWS))
    else $error("cursor outside the screen");

endmodule

bind text_console_char_writer_unit tccw_checker u_tccw_checker (.*);

`default_nettype wire

// ===== bench/tccw_console_checker.sv =====
`timescale 1ns / 1ps
// console checker: mirrors the screen grid, cursor and attribute register,
// predicts one result per accepted item and compares it on the result channel
// depends on tccw_pkg
module tccw_console_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  input  wire                             in_stall,
  input  wire  [tccw_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire  [tccw_pkg::CHAR_W-1:0]     in_char_code,
  input  wire  [tccw_pkg::INDEX_W-1:0]    in_cell_index,
  input  wire                             out_valid,
  input  wire                             out_stall,
  input  wire  [tccw_pkg::OUT_COL_W-1:0]  out_cursor_col,
  input  wire  [tccw_pkg::OUT_ROW_W-1:0]  out_cursor_row,
  input  wire  [tccw_pkg::CHAR_W-1:0]     out_cell_char,
  input  wire  [tccw_pkg::ATTR_W-1:0]     out_cell_attr,
  input  wire                             cfg_we,
  input  wire  [tccw_pkg::ATTR_W-1:0]     cfg_wdata,
  output int                              error_count,
  output int                              pending_count,
  output int                              result_count,
  output int                              scroll_count,
  output int                              read_count,
  output int                              clear_count
);
  import tccw_pkg::*;

  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic [CHAR_W-1:0]    ch;
    logic [ATTR_W-1:0]    attr;
  } cursor_report_t;

  localparam int MAX_REPORTS = 40;

  logic [ATTR_W+CHAR_W-1:0] screen_mirror [CELL_COUNT];
  int unsigned              cur_col;
  int unsigned              cur_row;
  logic [ATTR_W-1:0]        attr_mirror;
  cursor_report_t           cursor_reports_q [$];

  int errors  = 0;
  int results = 0;
  int scrolls = 0;
  int reads   = 0;
  int clears  = 0;

  function automatic void blank_cells(logic [ATTR_W-1:0] attr);
    for (int i = 0; i < CELL_COUNT; i++) screen_mirror[i] = {attr, BLANK_CHAR};
  endfunction

  function automatic void shift_rows_up();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_mirror[i] = screen_mirror[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
      screen_mirror[i] = {attr_mirror, BLANK_CHAR};
    cur_row = ROWS - 1;
    scrolls++;
  endfunction

  function automatic void next_line_if_wrapped();
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] c);
    if (c == CH_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else if (c == CH_RETURN) begin
      cur_col = 0;
    end else if (c == CH_BACKSPACE || c == CH_DELETE) begin
      // nothing happens at the left edge
      if (cur_col > 0) begin
        cur_col--;
        screen_mirror[cur_row * COLUMNS + cur_col] = {attr_mirror, BLANK_CHAR};
      end
    end else if (c == CH_TAB) begin
      cur_col = (cur_col + TAB_STOP) / TAB_STOP * TAB_STOP;
      next_line_if_wrapped();
    end else begin
      // every other byte is stored raw, high bytes included
      screen_mirror[cur_row * COLUMNS + cur_col] = {attr_mirror, c};
      cur_col++;
      next_line_if_wrapped();
    end
    if (cur_row >= ROWS) shift_rows_up();
  endfunction

  function automatic cursor_report_t apply_console_op(logic [OPCODE_W-1:0] op,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [INDEX_W-1:0] idx);
    cursor_report_t rep;
    rep = '0;
    case (op)
      OP_PUT: put_char(ch);
      OP_READ: begin
        reads++;
        // out of range reads give zero bytes
        if (int'(idx) < CELL_COUNT) begin
          rep.ch   = screen_mirror[idx][CHAR_W-1:0];
          rep.attr = screen_mirror[idx][ATTR_W+CHAR_W-1:CHAR_W];
        end
      end
      OP_CLEAR: begin
        clears++;
        blank_cells(attr_mirror);
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    rep.col = cur_col[OUT_COL_W-1:0];
    rep.row = cur_row[OUT_ROW_W-1:0];
    return rep;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t  result %0d %s: expected %0d actual %0d", $time, results, name, want, got);
      else if (errors == MAX_REPORTS + 1)
        $display("%0t  further mismatch reports suppressed", $time);
    end
  endtask

  always @(posedge clk) begin : monitor
    cursor_report_t want;
    if (!rst_n) begin
      blank_cells(RESET_ATTR);
      cur_col     = 0;
      cur_row     = 0;
      attr_mirror = RESET_ATTR;
      cursor_reports_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cursor_reports_q.size() == 0) begin
          errors++;
          $display("%0t  unexpected result: expected none actual col %0d row %0d char %0d attr %0d",
                   $time, out_cursor_col, out_cursor_row, out_cell_char, out_cell_attr);
        end else begin
          want = cursor_reports_q.pop_front();
          check_field("cursor_col", want.col, out_cursor_col);
          check_field("cursor_row", want.row, out_cursor_row);
          check_field("cell_char", want.ch, out_cell_char);
          check_field("cell_attr", want.attr, out_cell_attr);
          results++;
        end
      end
      if (cfg_we) attr_mirror = cfg_wdata;
      if (in_valid && !in_stall)
        cursor_reports_q.push_back(apply_console_op(in_opcode, in_char_code, in_cell_index));
    end
    pending_count <= cursor_reports_q.size();
    error_count   <= errors;
    result_count  <= results;
    scroll_count  <= scrolls;
    read_count    <= reads;
    clear_count   <= clears;
  end

endmodule

// ===== bench/tb_text_console_char_writer_unit.sv =====
`timescale 1ns / 1ps
// testbench top for the text console character writer: drives bursts of
// put/read/clear items and attribute writes, stalls the result side at random
// depends on tccw_pkg, tccw_console_checker and the block's RTL
module tb_text_console_char_writer_unit;
  import tccw_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_TOTAL  = 700;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_CYCLES = CELL_COUNT + 16;
  localparam int CYCLE_LIMIT  = 8000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OPCODE_W-1:0]  in_opcode;
  logic [CHAR_W-1:0]    in_char_code;
  logic [INDEX_W-1:0]   in_cell_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_COL_W-1:0] out_cursor_col;
  logic [OUT_ROW_W-1:0] out_cursor_row;
  logic [CHAR_W-1:0]    out_cell_char;
  logic [ATTR_W-1:0]    out_cell_attr;
  logic                 cfg_we;
  logic [ATTR_W-1:0]    cfg_wdata;

  int  error_count, pending_count, result_count, scroll_count, read_count, clear_count;
  int  cycle_count = 0;
  bit  rand_phase  = 0;
  bit  drain       = 0;

  text_console_char_writer_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  tccw_console_checker u_console_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .scroll_count   (scroll_count),
    .read_count     (read_count),
    .clear_count    (clear_count)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t  timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offers one item from the next falling edge and returns at its accepting edge
  task automatic send_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [INDEX_W-1:0] idx);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_char_code  <= ch;
    in_cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, INDEX_W'($urandom));
  endtask

  task automatic read_cell(logic [INDEX_W-1:0] idx);
    send_item(OP_READ, CHAR_W'($urandom), idx);
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic wait_idle();
    idle_cycles(1);
    while (pending_count != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_directed();
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h80);
    put_char(CH_DELETE);
    put_char(CH_BACKSPACE);
    put_char(CH_RETURN);
    // backspace at the left edge leaves everything alone
    put_char(CH_BACKSPACE);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    put_char(CH_NEWLINE);
    // ten tabs run past the last column and wrap to the next row
    repeat (10) put_char(CH_TAB);
    read_cell(INDEX_W'(CELL_COUNT - 1));
    read_cell(INDEX_W'(CELL_COUNT));
    read_cell(11'h7FF);
    send_item(OP_UNUSED, 8'hFF, 11'h7FF);
    send_item(OP_CLEAR, 8'h00, 11'h000);
  endtask

  task automatic random_item();
    logic [OPCODE_W-1:0] op;
    logic [CHAR_W-1:0]   ch;
    logic [INDEX_W-1:0]  idx;
    int                  pick;
    int                  sub;
    pick = $urandom_range(0, 999);
    sub  = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom);
    idx  = INDEX_W'($urandom);
    if (pick < 5) begin
      op = OP_CLEAR;
    end else if (pick < 25) begin
      op = OP_UNUSED;
    end else if (pick < 225) begin
      op = OP_READ;
      // favor the top and bottom rows where text tends to sit
      if (sub < 20)      idx = INDEX_W'($urandom_range(0, 2047));
      else if (sub < 50) idx = INDEX_W'($urandom_range(0, 3 * COLUMNS));
      else if (sub < 80) idx = INDEX_W'($urandom_range((ROWS - 5) * COLUMNS, CELL_COUNT - 1));
      else               idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
    end else begin
      op = OP_PUT;
      if (sub < 60)      ch = CHAR_W'($urandom);
      else if (sub < 74) ch = CH_NEWLINE;
      else if (sub < 79) ch = CH_RETURN;
      else if (sub < 86) ch = CH_BACKSPACE;
      else if (sub < 89) ch = CH_DELETE;
      else               ch = CH_TAB;
    end
    send_item(op, ch, idx);
  endtask

  task automatic run_random(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < n) begin
          random_item();
          sent++;
        end
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  initial begin : sender
    logic [ATTR_W-1:0] attr_plan [PHASES];
    attr_plan[0] = 8'hFF;
    attr_plan[1] = 8'h00;
    attr_plan[2] = ATTR_W'($urandom);
    attr_plan[3] = 8'h1E;
    attr_plan[4] = ATTR_W'($urandom);
    attr_plan[5] = RESET_ATTR;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block blanks the screen after reset with its input stalled
    @(posedge clk);
    while (in_stall) @(posedge clk);
    run_directed();
    wait_idle();
    for (int p = 0; p < PHASES; p++) begin
      write_attr(attr_plan[p]);
      rand_phase = 1'b1;
      run_random(ITEMS_TOTAL / PHASES);
      wait_idle();
    end
    drain = 1'b1;
    while (pending_count != 0) @(posedge clk);
    repeat (COLUMNS + 16) @(posedge clk);
    $display("checked %0d results: %0d reads, %0d clears, %0d scrolls, %0d attribute settings",
             result_count, read_count, clear_count, scroll_count, PHASES);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : receiver
    int seg_len;
    int mode;
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (drain) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end else if (rand_phase && !hold_done) begin
        // long hold-off so the queue fills and the input side stalls
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        seg_len = $urandom_range(8, 64);
        mode    = $urandom_range(0, 3);
        repeat (seg_len) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

endmodule

// ===== text_console_char_writer_unit.f =====
rtl/tccw_pkg.sv
rtl/tccw_front.sv
rtl/tccw_queue.sv
rtl/tccw_back.sv
rtl/text_console_char_writer_unit.sv
rtl/tccw_checker.sv
bench/tccw_console_checker.sv
bench/tb_text_console_char_writer_unit.sv
